@@ rtl/qwsi_pkg.sv @@
// Package: constants and the quarter-wave sine table for quarter_wave_sine_interp.
`timescale 1ns / 1ps
package qwsi_pkg;

    localparam int QUARTER_STEPS_DEF   = 256;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    localparam int ANGLE_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int TURN_BITS   = 48;
    localparam int ROM_LAST    = 256;
    localparam int ROM_ADDR_W  = 9;
    localparam int ROM_INDEX_W = 16;

    // 1/(2*pi) in Q32, positive, so one spare sign bit above 30 magnitude bits
    localparam logic signed [30:0] TURN_PER_RAD = 31'sd683565276;

    localparam logic signed [VALUE_W-1:0] SINE_ROM [0:ROM_LAST] = '{
        32'sd0, 32'sd6588356, 32'sd13176464, 32'sd19764076, 32'sd26350943,
        32'sd32936819, 32'sd39521455, 32'sd46104602, 32'sd52686014, 32'sd59265442,
        32'sd65842639, 32'sd72417357, 32'sd78989349, 32'sd85558366, 32'sd92124163,
        32'sd98686491, 32'sd105245103, 32'sd111799753, 32'sd118350194, 32'sd124896179,
        32'sd131437462, 32'sd137973796, 32'sd144504935, 32'sd151030634, 32'sd157550647,
        32'sd164064728, 32'sd170572633, 32'sd177074115, 32'sd183568930, 32'sd190056834,
        32'sd196537583, 32'sd203010932, 32'sd209476638, 32'sd215934457, 32'sd222384147,
        32'sd228825464, 32'sd235258165, 32'sd241682010, 32'sd248096755, 32'sd254502159,
        32'sd260897982, 32'sd267283981, 32'sd273659918, 32'sd280025552, 32'sd286380643,
        32'sd292724951, 32'sd299058239, 32'sd305380268, 32'sd311690799, 32'sd317989595,
        32'sd324276419, 32'sd330551034, 32'sd336813204, 32'sd343062693, 32'sd349299266,
        32'sd355522689, 32'sd361732726, 32'sd367929144, 32'sd374111709, 32'sd380280190,
        32'sd386434353, 32'sd392573967, 32'sd398698801, 32'sd404808624, 32'sd410903207,
        32'sd416982319, 32'sd423045732, 32'sd429093217, 32'sd435124548, 32'sd441139496,
        32'sd447137835, 32'sd453119340, 32'sd459083786, 32'sd465030947, 32'sd470960600,
        32'sd476872522, 32'sd482766489, 32'sd488642281, 32'sd494499676, 32'sd500338453,
        32'sd506158392, 32'sd511959275, 32'sd517740883, 32'sd523502998, 32'sd529245404,
        32'sd534967884, 32'sd540670223, 32'sd546352205, 32'sd552013618, 32'sd557654248,
        32'sd563273883, 32'sd568872310, 32'sd574449320, 32'sd580004702, 32'sd585538248,
        32'sd591049748, 32'sd596538995, 32'sd602005783, 32'sd607449906, 32'sd612871159,
        32'sd618269338, 32'sd623644239, 32'sd628995660, 32'sd634323400, 32'sd639627258,
        32'sd644907034, 32'sd650162530, 32'sd655393548, 32'sd660599890, 32'sd665781362,
        32'sd670937767, 32'sd676068911, 32'sd681174602, 32'sd686254647, 32'sd691308855,
        32'sd696337036, 32'sd701339000, 32'sd706314559, 32'sd711263525, 32'sd716185713,
        32'sd721080937, 32'sd725949013, 32'sd730789757, 32'sd735602987, 32'sd740388522,
        32'sd745146182, 32'sd749875788, 32'sd754577161, 32'sd759250125, 32'sd763894504,
        32'sd768510122, 32'sd773096806, 32'sd777654384, 32'sd782182683, 32'sd786681534,
        32'sd791150767, 32'sd795590213, 32'sd799999706, 32'sd804379079, 32'sd808728167,
        32'sd813046808, 32'sd817334838, 32'sd821592095, 32'sd825818421, 32'sd830013654,
        32'sd834177638, 32'sd838310216, 32'sd842411232, 32'sd846480531, 32'sd850517961,
        32'sd854523370, 32'sd858496606, 32'sd862437520, 32'sd866345964, 32'sd870221790,
        32'sd874064853, 32'sd877875009, 32'sd881652112, 32'sd885396022, 32'sd889106597,
        32'sd892783698, 32'sd896427186, 32'sd900036924, 32'sd903612776, 32'sd907154608,
        32'sd910662286, 32'sd914135678, 32'sd917574653, 32'sd920979082, 32'sd924348837,
        32'sd927683790, 32'sd930983817, 32'sd934248793, 32'sd937478595, 32'sd940673101,
        32'sd943832191, 32'sd946955747, 32'sd950043650, 32'sd953095785, 32'sd956112036,
        32'sd959092290, 32'sd962036435, 32'sd964944360, 32'sd967815955, 32'sd970651112,
        32'sd973449725, 32'sd976211688, 32'sd978936898, 32'sd981625251, 32'sd984276646,
        32'sd986890984, 32'sd989468165, 32'sd992008094, 32'sd994510675, 32'sd996975812,
        32'sd999403415, 32'sd1001793390, 32'sd1004145648, 32'sd1006460100, 32'sd1008736660,
        32'sd1010975242, 32'sd1013175761, 32'sd1015338134, 32'sd1017462281, 32'sd1019548121,
        32'sd1021595575, 32'sd1023604567, 32'sd1025575020, 32'sd1027506862, 32'sd1029400018,
        32'sd1031254418, 32'sd1033069992, 32'sd1034846671, 32'sd1036584389, 32'sd1038283080,
        32'sd1039942680, 32'sd1041563127, 32'sd1043144360, 32'sd1044686319, 32'sd1046188946,
        32'sd1047652185, 32'sd1049075980, 32'sd1050460278, 32'sd1051805027, 32'sd1053110176,
        32'sd1054375676, 32'sd1055601479, 32'sd1056787540, 32'sd1057933813, 32'sd1059040255,
        32'sd1060106826, 32'sd1061133483, 32'sd1062120190, 32'sd1063066909, 32'sd1063973603,
        32'sd1064840240, 32'sd1065666786, 32'sd1066453210, 32'sd1067199483, 32'sd1067905576,
        32'sd1068571464, 32'sd1069197120, 32'sd1069782521, 32'sd1070327646, 32'sd1070832474,
        32'sd1071296985, 32'sd1071721163, 32'sd1072104991, 32'sd1072448455, 32'sd1072751542,
        32'sd1073014240, 32'sd1073236540, 32'sd1073418433, 32'sd1073559913, 32'sd1073660973,
        32'sd1073721611, 32'sd1073741824
    };

endpackage

@@ rtl/qwsi_wave.sv @@
// Full-wave sample lookup: quadrant mirroring and sign over the quarter-wave table.
`timescale 1ns / 1ps
module qwsi_wave #(
    parameter int QUARTER_STEPS = qwsi_pkg::QUARTER_STEPS_DEF
) (
    input  logic [$clog2(QUARTER_STEPS)+1:0]     pos,
    output logic signed [qwsi_pkg::VALUE_W-1:0]  sample
);

    localparam int SB = $clog2(QUARTER_STEPS) + 2;
    localparam logic [SB-1:0] Q1 = SB'(QUARTER_STEPS);
    localparam logic [SB-1:0] Q2 = SB'(2 * QUARTER_STEPS);
    localparam logic [SB-1:0] Q3 = SB'(3 * QUARTER_STEPS);

    logic [SB-1:0]                          k;
    logic                                   neg;
    logic [qwsi_pkg::ROM_INDEX_W-1:0]       k_wide;
    logic [qwsi_pkg::ROM_ADDR_W-1:0]        k_rom;
    logic signed [qwsi_pkg::VALUE_W-1:0]    rom_val;

    always_comb begin
        if (pos <= Q1) begin
            k   = pos;
            neg = 1'b0;
        end else if (pos <= Q2) begin
            k   = Q2 - pos;
            neg = 1'b0;
        end else if (pos <= Q3) begin
            k   = pos - Q2;
            neg = 1'b1;
        end else begin
            k   = SB'(0) - pos;   // 4Q - pos, wraps modulo a turn
            neg = 1'b1;
        end
    end

    // table holds a fixed 257 samples; index saturates at its last entry
    assign k_wide  = qwsi_pkg::ROM_INDEX_W'(k);
    assign k_rom   = (k_wide > qwsi_pkg::ROM_INDEX_W'(qwsi_pkg::ROM_LAST))
                   ? qwsi_pkg::ROM_ADDR_W'(qwsi_pkg::ROM_LAST)
                   : k_wide[qwsi_pkg::ROM_ADDR_W-1:0];
    assign rom_val = qwsi_pkg::SINE_ROM[k_rom];
    assign sample  = neg ? -rom_val : rom_val;

endmodule

@@ rtl/quarter_wave_sine_interp.sv @@
// Top level: pipelined table sine/cosine with linear interpolation.
//
//  channel | ports                         | dir | beat
//  --------+-------------------------------+-----+---------------------------
//  input   | s_valid s_ready s_op s_angle  | in  | op select, Q16.16 radians
//  result  | m_valid m_ready m_value       | out | Q30 sine or cosine
//
//  Five register stages: turn multiply, table lookup, difference,
//  interpolation multiply, final add into the output register.
//  One beat per cycle sustained while m_ready stays high.
//  aresetn is synchronous, active low, and clears the stage valid bits only.
//  A stall at m_ready freezes each full stage; empty stages keep filling.
`timescale 1ns / 1ps
module quarter_wave_sine_interp #(
    parameter int QUARTER_STEPS   = qwsi_pkg::QUARTER_STEPS_DEF,
    parameter int PHASE_FRAC_BITS = qwsi_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [qwsi_pkg::ANGLE_W-1:0]  s_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qwsi_pkg::VALUE_W-1:0]  m_value
);

    localparam int SB   = $clog2(QUARTER_STEPS) + 2;
    localparam int TB   = qwsi_pkg::TURN_BITS;
    localparam int FB   = PHASE_FRAC_BITS;
    localparam int DW   = qwsi_pkg::VALUE_W + 1;
    localparam int PW   = DW + FB + 1;
    localparam int MW   = qwsi_pkg::ANGLE_W + 31;
    localparam logic [SB-1:0] Q1 = SB'(QUARTER_STEPS);

    // stage valids and readies
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !m_valid_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    // stage 1: angle to turns, keep the fraction of a turn
    logic signed [MW-1:0] turn;
    logic [TB-1:0]        tfrac_reg;
    logic                 op1_reg;

    assign turn = MW'(s_angle) * MW'(qwsi_pkg::TURN_PER_RAD);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            tfrac_reg <= turn[TB-1:0];
            op1_reg   <= s_op;
        end
    end

    // stage 2: index, fraction, two adjacent samples
    logic [SB-1:0]                        index;
    logic [SB-1:0]                        pos_a;
    logic [SB-1:0]                        pos_b;
    logic [FB-1:0]                        frac;
    logic signed [qwsi_pkg::VALUE_W-1:0]  samp_a;
    logic signed [qwsi_pkg::VALUE_W-1:0]  samp_b;
    logic signed [qwsi_pkg::VALUE_W-1:0]  a2_reg;
    logic signed [qwsi_pkg::VALUE_W-1:0]  b2_reg;
    logic [FB-1:0]                        frac2_reg;

    assign index = tfrac_reg[TB-1 -: SB];
    assign frac  = tfrac_reg[TB-1-SB -: FB];
    assign pos_a = op1_reg ? index + Q1 : index;
    assign pos_b = pos_a + SB'(1);

    qwsi_wave #(
        .QUARTER_STEPS (QUARTER_STEPS)
    ) u_wave_a (
        .pos    (pos_a),
        .sample (samp_a)
    );

    qwsi_wave #(
        .QUARTER_STEPS (QUARTER_STEPS)
    ) u_wave_b (
        .pos    (pos_b),
        .sample (samp_b)
    );

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            a2_reg    <= samp_a;
            b2_reg    <= samp_b;
            frac2_reg <= frac;
        end
    end

    // stage 3: sample difference
    logic signed [DW-1:0]                 diff3_reg;
    logic signed [qwsi_pkg::VALUE_W-1:0]  a3_reg;
    logic [FB-1:0]                        frac3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            diff3_reg <= DW'(b2_reg) - DW'(a2_reg);
            a3_reg    <= a2_reg;
            frac3_reg <= frac2_reg;
        end
    end

    // stage 4: slope times fraction
    logic signed [PW-1:0]                 prod4;
    logic signed [PW-1:0]                 prod4_reg;
    logic signed [qwsi_pkg::VALUE_W-1:0]  a4_reg;

    assign prod4 = PW'(diff3_reg) * PW'($signed({1'b0, frac3_reg}));

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            prod4_reg <= prod4;
            a4_reg    <= a3_reg;
        end
    end

    // stage 5: floor shift and add
    logic signed [PW-1:0]                 t_shift;
    logic signed [qwsi_pkg::VALUE_W-1:0]  value_reg;

    assign t_shift = prod4_reg >>> FB;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            value_reg <= a4_reg + t_shift[qwsi_pkg::VALUE_W-1:0];
        end
    end

    assign m_value = value_reg;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted beat did not enter the first stage");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v4_reg))
        else $error("result raised without a beat in the last stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !rdy2 |=> v1_reg)
        else $error("first stage lost a beat under stall");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value >= -32'sd1073741824) && (m_value <= 32'sd1073741824))
        else $error("result outside unit range");
`endif

endmodule

@@ tb/tb_quarter_wave_sine_interp.sv @@
// Testbench for quarter_wave_sine_interp: angle beats in, table sine/cosine checked.
`timescale 1ns / 1ps
module tb_quarter_wave_sine_interp;

    localparam int unsigned QUARTER      = qwsi_pkg::QUARTER_STEPS_DEF;
    localparam int unsigned STEPS        = 4 * QUARTER;
    localparam int unsigned FRAC_BITS    = qwsi_pkg::PHASE_FRAC_BITS_DEF;
    localparam int unsigned TURN_W       = 48;
    localparam longint TURN_PER_RAD      = 64'sd683565276;
    localparam longint unsigned TURN_MASK = (64'd1 << TURN_W) - 64'd1;
    localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
    localparam int RANDOM_ITEMS          = 1126;
    localparam int LONG_HOLD             = 80;

    class sine_scoreboard;
        logic signed [31:0] expected_values[$];
        int unsigned beats_in, beats_out, cos_beats, neg_beats, mismatches;

        function longint quarter_sample(int unsigned k);
            return longint'(qwsi_pkg::SINE_ROM[k > qwsi_pkg::ROM_LAST ? qwsi_pkg::ROM_LAST : k]);
        endfunction

        function longint wave_sample(int unsigned pos);
            int unsigned p;
            p = pos % STEPS;
            if (p <= QUARTER) return quarter_sample(p);
            if (p <= 2 * QUARTER) return quarter_sample(2 * QUARTER - p);
            if (p <= 3 * QUARTER) return -quarter_sample(p - 2 * QUARTER);
            return -quarter_sample(STEPS - p);
        endfunction

        function logic signed [31:0] sample_value(bit cosine, logic signed [31:0] angle);
            longint turn;
            longint unsigned phase;
            int unsigned pos;
            longint frac, a, b, t;
            turn  = longint'(angle) * TURN_PER_RAD;
            phase = (($unsigned(turn) & TURN_MASK) * STEPS) >> (TURN_W - FRAC_BITS);
            pos   = 32'(phase >> FRAC_BITS);
            frac  = phase & FRAC_MASK;
            if (cosine) pos += QUARTER;
            a = wave_sample(pos);
            b = wave_sample(pos + 1);
            // arithmetic shift gives the floor for negative slopes
            t = ((b - a) * frac) >>> FRAC_BITS;
            return 32'(a + t);
        endfunction

        function void note_input(bit cosine, logic signed [31:0] angle);
            beats_in++;
            if (cosine) cos_beats++;
            if (angle < 0) neg_beats++;
            expected_values.push_back(sample_value(cosine, angle));
        endfunction

        function void check_result(logic signed [31:0] got);
            logic signed [31:0] want;
            beats_out++;
            if (expected_values.size() == 0) begin
                $error("value: expected no beat, actual %0d", got);
                mismatches++;
            end else begin
                want = expected_values.pop_front();
                if (got !== want) begin
                    $error("value: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic signed [31:0] s_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_value;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    bit rx_hold  = 1'b0;

    sine_scoreboard sb = new();

    quarter_wave_sine_interp DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_angle (s_angle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    always #5 aclk = ~aclk;

    task automatic send_angle(input bit cosine, input logic signed [31:0] angle);
        if (idle_on && !rx_hold && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= cosine;
        s_angle <= angle;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cosine, angle);
    endtask

    initial begin
        int directed_angles[12];
        int ang;
        // zero, unit steps, extremes, quarter turns, last step of a turn, negatives
        directed_angles = '{0, 1, -1, 32'h7FFFFFFF, 32'h80000000, 102944, 205887,
                            308831, 411500, 411775, -102944, -411500};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_angles[i]) begin
            send_angle(1'b0, directed_angles[i]);
            send_angle(1'b1, directed_angles[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 450) hold_req = 1'b1;
            if (i == RANDOM_ITEMS - 150) idle_on = 1'b0;
            case ($urandom_range(0, 3))
                0, 1: ang = $urandom;
                2: ang = int'($urandom_range(0, 823550)) - 411775;
                default: ang = (int'($urandom_range(0, 16)) - 8) * 102944
                               + int'($urandom_range(0, 80)) - 40;
            endcase
            send_angle(1'($urandom_range(0, 1)), ang);
        end
        s_valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        $display("Sent %0d angle beats (%0d cosine, %0d negative), incl. a long output stall",
                 sb.beats_in, sb.cos_beats, sb.neg_beats);
        $display("Checked %0d result beats, %0d mismatches", sb.beats_out, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                rx_hold  = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold  = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_value);
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
